### sv/csvfs_pkg.sv
// Shared types and constants of the CSV record and field splitter.
package csvfs_pkg;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [7:0] SEP_RESET = CH_COMMA;

	localparam int QUEUE_DEPTH = 2;

	localparam int KIND_W    = 3;
	localparam int BYTE_W    = 8;
	localparam int FNUM_W    = 8;
	localparam int FCOUNT_W  = 9;

	localparam logic [KIND_W-1:0] KIND_BYTE      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FIELD_END = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REC_END   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EMPTY_REC = 3'd3;
	localparam logic [KIND_W-1:0] KIND_STREAM    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_REC_EOS   = 3'd5;

	// One classified input item as it travels from the front to the back.
	typedef struct packed {
		logic              eos;
		logic              cr;
		logic              lf;
		logic              quote;
		logic              sep;
		logic [BYTE_W-1:0] data;
	} token_t;

endpackage

### sv/csvfs_front.sv
// Front end: separator register, input handshake and byte classification.
module csvfs_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sep_we,
	input  logic [7:0]             sep_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_stream,
	input  logic                   queue_full,
	output logic                   push,
	output csvfs_pkg::token_t      push_token
);
	import csvfs_pkg::*;

	logic [7:0] separator_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q <= SEP_RESET;
		end else if (sep_we) begin
			separator_q <= sep_wdata;
		end
	end

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		push_token.eos   = end_of_stream;
		push_token.cr    = (data_byte == CH_CR);
		push_token.lf    = (data_byte == CH_LF);
		push_token.quote = (data_byte == CH_QUOTE);
		push_token.sep   = (data_byte == separator_q);
		push_token.data  = data_byte;
	end

endmodule

### sv/csvfs_queue.sv
// Short token queue that decouples the classifier from the parser.
module csvfs_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  csvfs_pkg::token_t      push_token,
	output logic                   full,
	input  logic                   pop,
	output logic                   head_valid,
	output csvfs_pkg::token_t      head_token
);
	import csvfs_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	token_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_token = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_token;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/csvfs_back.sv
// Back end: parser state machine, field counting and the result register.
module csvfs_back #(
	parameter int MAX_FIELDS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  csvfs_pkg::token_t               head_token,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [csvfs_pkg::KIND_W-1:0]    result_kind,
	output logic [csvfs_pkg::BYTE_W-1:0]    out_byte,
	output logic [csvfs_pkg::FNUM_W-1:0]    field_number,
	output logic [csvfs_pkg::FCOUNT_W-1:0]  field_count,
	output logic                            field_overflow
);
	import csvfs_pkg::*;

	localparam int CW = (MAX_FIELDS > 2) ? $clog2(MAX_FIELDS) : 1;
	localparam int EW = (CW > FCOUNT_W) ? CW + 1 : FCOUNT_W + 1;
	localparam logic [CW-1:0] LAST_FIELD = CW'(MAX_FIELDS - 1);

	typedef enum logic [4:0] {
		PH_START    = 5'b00001,
		PH_UNQUOTED = 5'b00010,
		PH_QUOTED   = 5'b00100,
		PH_QSEEN    = 5'b01000,
		PH_AFTER    = 5'b10000
	} phase_t;

	phase_t          phase_q, phase_d;
	logic            swallow_q, swallow_d;
	logic [CW-1:0]   field_q, field_d;
	logic            has_bytes_q, has_bytes_d;
	logic            ovf_q, ovf_d;

	logic            out_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [FNUM_W-1:0]   num_q;
	logic [FCOUNT_W-1:0] count_q;
	logic                fovf_q;

	logic            emit;
	logic            do_byte, do_fend, do_rend;
	logic [KIND_W-1:0]   kind_d;
	logic [BYTE_W-1:0]   byte_d;
	logic [FNUM_W-1:0]   num_d;
	logic [FCOUNT_W-1:0] count_d;
	logic                fovf_d;
	logic [EW-1:0]       field_ext;
	logic [EW-1:0]       field_inc;

	assign field_ext = EW'(field_q);
	assign field_inc = field_ext + EW'(1);

	always_comb begin
		phase_d     = phase_q;
		swallow_d   = 1'b0;
		field_d     = field_q;
		has_bytes_d = has_bytes_q;
		ovf_d       = ovf_q;
		do_byte     = 1'b0;
		do_fend     = 1'b0;
		do_rend     = 1'b0;

		if (head_token.eos) begin
			do_rend = 1'b1;
		end else if (head_token.lf && swallow_q) begin
			// Second half of a CR LF pair: dropped.
		end else if (head_token.cr || head_token.lf) begin
			swallow_d = head_token.cr;
			do_rend   = 1'b1;
		end else begin
			has_bytes_d = 1'b1;
			case (phase_q)
				PH_START: begin
					if (head_token.quote) begin
						phase_d = PH_QUOTED;
					end else if (head_token.sep) begin
						do_fend = 1'b1;
					end else begin
						phase_d = PH_UNQUOTED;
						do_byte = 1'b1;
					end
				end
				PH_QUOTED: begin
					if (head_token.quote) begin
						phase_d = PH_QSEEN;
					end else begin
						do_byte = 1'b1;
					end
				end
				PH_QSEEN: begin
					if (head_token.quote) begin
						phase_d = PH_QUOTED;
						do_byte = 1'b1;
					end else if (head_token.sep) begin
						do_fend = 1'b1;
					end else begin
						phase_d = PH_AFTER;
						do_byte = 1'b1;
					end
				end
				PH_AFTER: begin
					if (head_token.sep) begin
						do_fend = 1'b1;
					end else begin
						do_byte = 1'b1;
					end
				end
				PH_UNQUOTED: begin
					if (head_token.sep) begin
						do_fend = 1'b1;
					end else begin
						do_byte = 1'b1;
					end
				end
				default: begin
					phase_d = PH_START;
				end
			endcase
		end

		emit    = do_byte || do_fend || do_rend;
		kind_d  = KIND_BYTE;
		byte_d  = '0;
		num_d   = field_ext[FNUM_W-1:0];
		count_d = '0;
		fovf_d  = ovf_q;

		if (do_byte) begin
			byte_d = head_token.data;
		end

		if (do_fend) begin
			kind_d  = KIND_FIELD_END;
			phase_d = PH_START;
			if (field_q != LAST_FIELD) begin
				field_d = field_q + 1'b1;
			end else begin
				ovf_d = 1'b1;
			end
		end

		if (do_rend) begin
			if (has_bytes_q) begin
				kind_d  = head_token.eos ? KIND_REC_EOS : KIND_REC_END;
				count_d = field_inc[FCOUNT_W-1:0];
			end else begin
				kind_d = head_token.eos ? KIND_STREAM : KIND_EMPTY_REC;
				num_d  = '0;
				fovf_d = 1'b0;
			end
			phase_d     = PH_START;
			field_d     = '0;
			has_bytes_d = 1'b0;
			ovf_d       = 1'b0;
		end
	end

	// A token leaves the queue whenever the result register is free or being emptied.
	assign pop = head_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			swallow_q   <= 1'b0;
			field_q     <= '0;
			has_bytes_q <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				swallow_q   <= swallow_d;
				field_q     <= field_d;
				has_bytes_q <= has_bytes_d;
				ovf_q       <= ovf_d;
				out_valid_q <= emit;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			kind_q  <= kind_d;
			byte_q  <= byte_d;
			num_q   <= num_d;
			count_q <= count_d;
			fovf_q  <= fovf_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = kind_q;
	assign out_byte       = byte_q;
	assign field_number   = num_q;
	assign field_count    = count_q;
	assign field_overflow = fovf_q;

	a_count_on_rec_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == KIND_REC_END || kind_q == KIND_REC_EOS)
		|-> count_q != '0)
		else $error("record end carries a zero field count");

	a_empty_rec_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == KIND_EMPTY_REC || kind_q == KIND_STREAM)
		|-> num_q == '0 && !fovf_q && count_q == '0)
		else $error("empty record or stream end carries field information");

	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> field_q == LAST_FIELD)
		else $error("overflow flag set while field index is not saturated");

	a_fresh_record: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !has_bytes_q && !head_token.eos && !head_token.cr && !head_token.lf
		|-> field_q == '0 && !ovf_q)
		else $error("record without bytes has a nonzero field state");

endmodule

### sv/csv_record_field_splitter_unit.sv
// Top level: a CSV byte stream splitter that takes one byte per clock while in_stall is low
// and emits fields and records. This unit takes one item (a text byte or an end-of-stream mark)
// per clock while in_stall is low and gives at most one result per item; empty cycles on either
// side cost nothing but the time they last. An accepted item is written into the two-entry
// token queue behind the classifier, and the parser then loads its result from the queue head
// into its result register, from which it can be taken. The parser state machine updates its
// state on every pop, so it sustains one item per clock while the output is taken. The separator
// register resets to comma and must be written only while the unit holds no pending item.
// Records end at CR, LF or CR LF; the field index saturates at MAX_FIELDS-1 with an overflow flag.
module csv_record_field_splitter_unit #(
	parameter int MAX_FIELDS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sep_we,
	input  logic [7:0]                      sep_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            end_of_stream,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [csvfs_pkg::KIND_W-1:0]    result_kind,
	output logic [csvfs_pkg::BYTE_W-1:0]    out_byte,
	output logic [csvfs_pkg::FNUM_W-1:0]    field_number,
	output logic [csvfs_pkg::FCOUNT_W-1:0]  field_count,
	output logic                            field_overflow
);
	import csvfs_pkg::*;

	logic   push;
	token_t push_token;
	logic   queue_full;
	logic   pop;
	logic   head_valid;
	token_t head_token;

	csvfs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.sep_we        (sep_we),
		.sep_wdata     (sep_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.queue_full    (queue_full),
		.push          (push),
		.push_token    (push_token)
	);

	csvfs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_token (push_token),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_token (head_token)
	);

	csvfs_back #(
		.MAX_FIELDS (MAX_FIELDS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_token     (head_token),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.out_byte       (out_byte),
		.field_number   (field_number),
		.field_count    (field_count),
		.field_overflow (field_overflow)
	);

endmodule
